FILE: rtl/ekf_pkg.sv
`default_nettype none

package ekf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 32;
    localparam int PROD_W     = 2 * IN_W;
    localparam int TERM_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W      = TERM_W + 2;
    localparam int ACC_W      = 64;
    localparam int FIELD_W    = 48;
    localparam int PC_W       = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_Z = 2'd2;

    localparam logic [PC_W-1:0] FIELD_START = 5'd0;
    localparam logic [PC_W-1:0] PAIR_START  = 5'd10;

    typedef enum logic [2:0] {
        MA_COS,
        MA_SIN,
        MA_W,
        MA_DX,
        MA_DY,
        MA_DZ
    } mula_sel_t;

    typedef enum logic [2:0] {
        MB_AV,
        MB_BV,
        MB_PREF,
        MB_KX,
        MB_KY,
        MB_KZ,
        MB_W
    } mulb_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SUM_LD,
        OP_SUM_ADD,
        OP_W_SUM,
        OP_W_PROD,
        OP_ACC_X,
        OP_ACC_Y,
        OP_ACC_Z,
        OP_RES_A,
        OP_RES_B
    } dp_op_t;

    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_END_FIELD,
        SQ_END_PAIR
    } seq_op_t;

    typedef struct packed {
        mula_sel_t mula;
        mulb_sel_t mulb;
        dp_op_t    op;
        seq_op_t   seq;
    } ctrl_word_t;

    // The op field consumes the product registered by the previous step.
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{MA_COS, MB_AV, OP_NONE, SQ_NEXT};
        case (pc)
            5'd0:  w = '{MA_COS, MB_AV,   OP_NONE,    SQ_NEXT};
            5'd1:  w = '{MA_SIN, MB_BV,   OP_SUM_LD,  SQ_NEXT};
            5'd2:  w = '{MA_COS, MB_AV,   OP_W_SUM,   SQ_NEXT};
            5'd3:  w = '{MA_W,   MB_PREF, OP_NONE,    SQ_NEXT};
            5'd4:  w = '{MA_COS, MB_AV,   OP_W_PROD,  SQ_NEXT};
            5'd5:  w = '{MA_W,   MB_KX,   OP_NONE,    SQ_NEXT};
            5'd6:  w = '{MA_W,   MB_KY,   OP_ACC_X,   SQ_NEXT};
            5'd7:  w = '{MA_W,   MB_KZ,   OP_ACC_Y,   SQ_NEXT};
            5'd8:  w = '{MA_COS, MB_AV,   OP_ACC_Z,   SQ_NEXT};
            5'd9:  w = '{MA_COS, MB_AV,   OP_NONE,    SQ_END_FIELD};
            5'd10: w = '{MA_DX,  MB_KX,   OP_NONE,    SQ_NEXT};
            5'd11: w = '{MA_DY,  MB_KY,   OP_SUM_LD,  SQ_NEXT};
            5'd12: w = '{MA_DZ,  MB_KZ,   OP_SUM_ADD, SQ_NEXT};
            5'd13: w = '{MA_COS, MB_AV,   OP_W_SUM,   SQ_NEXT};
            5'd14: w = '{MA_COS, MB_W,    OP_NONE,    SQ_NEXT};
            5'd15: w = '{MA_SIN, MB_W,    OP_RES_A,   SQ_NEXT};
            5'd16: w = '{MA_COS, MB_AV,   OP_RES_B,   SQ_NEXT};
            5'd17: w = '{MA_COS, MB_AV,   OP_NONE,    SQ_END_PAIR};
            default: w = '{MA_COS, MB_AV, OP_NONE,    SQ_END_PAIR};
        endcase
        return w;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_WIDTH-1:0] r;
        if (v[SUM_W-1:DATA_WIDTH-1] == '0 || v[SUM_W-1:DATA_WIDTH-1] == '1) begin
            r = v[DATA_WIDTH-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [ACC_W-1:0] v);
        logic signed [FIELD_W-1:0] r;
        if (v[ACC_W-1:FIELD_W-1] == '0 || v[ACC_W-1:FIELD_W-1] == '1) begin
            r = v[FIELD_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(FIELD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(FIELD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ewald_kspace_field_block.sv
// Channel  Handshake             Beat contents
// input    in_valid, in_stall    operation, a_val, b_val, cos_val, sin_val, pref_val,
//                                kx, ky, kz, is_last
// result   out_valid, out_stall  result_kind, a_new, b_new, field_x, field_y, field_z
// config   cfg_valid, cfg_ready  cfg_index, cfg_data
//
// One input beat is processed at a time by a microcode program on one shared 32x32 multiplier.
// The final program step waits only while an earlier result beat is still held and stalled.
// The next input beat is taken while a finished result waits in the output register.
// Reset clears the displacement registers, accumulators, busy flag, pc_reg and out_valid.
`default_nettype none

module ewald_kspace_field_block (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   operation,
    input  wire logic signed [ekf_pkg::IN_W-1:0]        a_val,
    input  wire logic signed [ekf_pkg::IN_W-1:0]        b_val,
    input  wire logic signed [ekf_pkg::IN_W-1:0]        cos_val,
    input  wire logic signed [ekf_pkg::IN_W-1:0]        sin_val,
    input  wire logic signed [ekf_pkg::IN_W-1:0]        pref_val,
    input  wire logic signed [ekf_pkg::IN_W-1:0]        kx,
    input  wire logic signed [ekf_pkg::IN_W-1:0]        ky,
    input  wire logic signed [ekf_pkg::IN_W-1:0]        kz,
    input  wire logic                                   is_last,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        result_kind,
    output logic signed [ekf_pkg::IN_W-1:0]             a_new,
    output logic signed [ekf_pkg::IN_W-1:0]             b_new,
    output logic signed [ekf_pkg::FIELD_W-1:0]          field_x,
    output logic signed [ekf_pkg::FIELD_W-1:0]          field_y,
    output logic signed [ekf_pkg::FIELD_W-1:0]          field_z,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [ekf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic signed [ekf_pkg::IN_W-1:0]        cfg_data
);

    localparam int IN_W    = ekf_pkg::IN_W;
    localparam int PROD_W  = ekf_pkg::PROD_W;
    localparam int TERM_W  = ekf_pkg::TERM_W;
    localparam int SUM_W   = ekf_pkg::SUM_W;
    localparam int ACC_W   = ekf_pkg::ACC_W;
    localparam int FIELD_W = ekf_pkg::FIELD_W;
    localparam int DW      = ekf_pkg::DATA_WIDTH;
    localparam int FB      = ekf_pkg::FRAC_BITS;
    localparam int PC_W    = ekf_pkg::PC_W;

    logic                      busy_reg, busy_next;
    logic [PC_W-1:0]           pc_reg, pc_next;
    logic                      op_reg, op_next;
    logic                      last_reg, last_next;
    logic signed [IN_W-1:0]    av_reg, av_next, bv_reg, bv_next;
    logic signed [IN_W-1:0]    cv_reg, cv_next, sv_reg, sv_next, pv_reg, pv_next;
    logic signed [IN_W-1:0]    kx_reg, kx_next, ky_reg, ky_next, kz_reg, kz_next;
    logic signed [IN_W-1:0]    dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [DW-1:0]      w_reg, w_next;
    logic signed [DW-1:0]      ra_reg, ra_next, rb_reg, rb_next;
    logic signed [ACC_W-1:0]   accx_reg, accx_next, accy_reg, accy_next, accz_reg, accz_next;
    logic                      ovalid_reg, ovalid_next;
    logic                      okind_reg, okind_next;
    logic signed [IN_W-1:0]    oa_reg, oa_next, ob_reg, ob_next;
    logic signed [FIELD_W-1:0] ofx_reg, ofx_next, ofy_reg, ofy_next, ofz_reg, ofz_next;

    ekf_pkg::ctrl_word_t       ctrl;
    logic signed [IN_W-1:0]    mul_a, mul_b;
    logic signed [TERM_W-1:0]  term;
    logic signed [SUM_W-1:0]   term_ext;
    logic signed [ACC_W-1:0]   acc_sel;
    logic signed [ACC_W:0]     acc_sum;
    logic signed [ACC_W-1:0]   acc_sat;
    logic                      out_free;
    logic                      emit_field;
    logic                      emit_pair;

    assign in_stall    = busy_reg;
    assign cfg_ready   = 1'b1;
    assign out_valid   = ovalid_reg;
    assign result_kind = okind_reg;
    assign a_new       = oa_reg;
    assign b_new       = ob_reg;
    assign field_x     = ofx_reg;
    assign field_y     = ofy_reg;
    assign field_z     = ofz_reg;

    always_comb
    begin
        ctrl     = ekf_pkg::ucode(pc_reg);
        term     = prod_reg[PROD_W-1:FB];
        term_ext = {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
        out_free = !ovalid_reg || !out_stall;

        unique case (ctrl.mula)
            ekf_pkg::MA_COS: mul_a = cv_reg;
            ekf_pkg::MA_SIN: mul_a = sv_reg;
            ekf_pkg::MA_W:   mul_a = IN_W'(w_reg);
            ekf_pkg::MA_DX:  mul_a = dx_reg;
            ekf_pkg::MA_DY:  mul_a = dy_reg;
            ekf_pkg::MA_DZ:  mul_a = dz_reg;
            default:         mul_a = cv_reg;
        endcase

        unique case (ctrl.mulb)
            ekf_pkg::MB_AV:   mul_b = av_reg;
            ekf_pkg::MB_BV:   mul_b = bv_reg;
            ekf_pkg::MB_PREF: mul_b = pv_reg;
            ekf_pkg::MB_KX:   mul_b = kx_reg;
            ekf_pkg::MB_KY:   mul_b = ky_reg;
            ekf_pkg::MB_KZ:   mul_b = kz_reg;
            ekf_pkg::MB_W:    mul_b = IN_W'(w_reg);
            default:          mul_b = av_reg;
        endcase

        prod_next = mul_a * mul_b;

        unique case (ctrl.op)
            ekf_pkg::OP_ACC_Y: acc_sel = accy_reg;
            ekf_pkg::OP_ACC_Z: acc_sel = accz_reg;
            default:           acc_sel = accx_reg;
        endcase
        acc_sum = {acc_sel[ACC_W-1], acc_sel} + {{(ACC_W+1-TERM_W){term[TERM_W-1]}}, term};
        if (acc_sum[ACC_W] == acc_sum[ACC_W-1]) begin
            acc_sat = acc_sum[ACC_W-1:0];
        end else if (acc_sum[ACC_W]) begin
            acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
        end

        busy_next   = busy_reg;
        pc_next     = pc_reg;
        op_next     = op_reg;
        last_next   = last_reg;
        av_next     = av_reg;
        bv_next     = bv_reg;
        cv_next     = cv_reg;
        sv_next     = sv_reg;
        pv_next     = pv_reg;
        kx_next     = kx_reg;
        ky_next     = ky_reg;
        kz_next     = kz_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        dz_next     = dz_reg;
        sum_next    = sum_reg;
        w_next      = w_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        accx_next   = accx_reg;
        accy_next   = accy_reg;
        accz_next   = accz_reg;
        ovalid_next = ovalid_reg;
        okind_next  = okind_reg;
        oa_next     = oa_reg;
        ob_next     = ob_reg;
        ofx_next    = ofx_reg;
        ofy_next    = ofy_reg;
        ofz_next    = ofz_reg;
        emit_field  = 1'b0;
        emit_pair   = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                ekf_pkg::CFG_DELTA_X: dx_next = cfg_data;
                ekf_pkg::CFG_DELTA_Y: dy_next = cfg_data;
                ekf_pkg::CFG_DELTA_Z: dz_next = cfg_data;
                default:              ;
            endcase
        end

        if (in_valid && !busy_reg) begin
            busy_next = 1'b1;
            pc_next   = operation ? ekf_pkg::PAIR_START : ekf_pkg::FIELD_START;
            op_next   = operation;
            last_next = is_last;
            av_next   = a_val;
            bv_next   = b_val;
            cv_next   = cos_val;
            sv_next   = sin_val;
            pv_next   = pref_val;
            kx_next   = kx;
            ky_next   = ky;
            kz_next   = kz;
        end

        if (ovalid_reg && !out_stall) begin
            ovalid_next = 1'b0;
        end

        if (busy_reg) begin
            unique case (ctrl.op)
                ekf_pkg::OP_NONE:    ;
                ekf_pkg::OP_SUM_LD:  sum_next = term_ext;
                ekf_pkg::OP_SUM_ADD: sum_next = sum_reg + term_ext;
                ekf_pkg::OP_W_SUM:   w_next = ekf_pkg::sat_data(sum_reg + term_ext);
                ekf_pkg::OP_W_PROD:  w_next = ekf_pkg::sat_data(term_ext);
                ekf_pkg::OP_ACC_X:   accx_next = acc_sat;
                ekf_pkg::OP_ACC_Y:   accy_next = acc_sat;
                ekf_pkg::OP_ACC_Z:   accz_next = acc_sat;
                ekf_pkg::OP_RES_A:
                    ra_next = ekf_pkg::sat_data({{(SUM_W-IN_W){av_reg[IN_W-1]}}, av_reg} + term_ext);
                ekf_pkg::OP_RES_B:
                    rb_next = ekf_pkg::sat_data({{(SUM_W-IN_W){bv_reg[IN_W-1]}}, bv_reg} + term_ext);
                default:             ;
            endcase

            unique case (ctrl.seq)
                ekf_pkg::SQ_NEXT:
                    pc_next = PC_W'(pc_reg + 1'b1);
                ekf_pkg::SQ_END_FIELD:
                begin
                    if (!last_reg) begin
                        busy_next = 1'b0;
                    end else if (out_free) begin
                        emit_field = 1'b1;
                        busy_next  = 1'b0;
                    end
                end
                ekf_pkg::SQ_END_PAIR:
                begin
                    if (out_free) begin
                        emit_pair = 1'b1;
                        busy_next = 1'b0;
                    end
                end
                default:
                    busy_next = 1'b0;
            endcase
        end

        if (emit_field) begin
            ovalid_next = 1'b1;
            okind_next  = 1'b1;
            oa_next     = '0;
            ob_next     = '0;
            ofx_next    = ekf_pkg::sat_field(accx_reg);
            ofy_next    = ekf_pkg::sat_field(accy_reg);
            ofz_next    = ekf_pkg::sat_field(accz_reg);
            accx_next   = '0;
            accy_next   = '0;
            accz_next   = '0;
        end

        if (emit_pair) begin
            ovalid_next = 1'b1;
            okind_next  = 1'b0;
            oa_next     = IN_W'(ra_reg);
            ob_next     = IN_W'(rb_reg);
            ofx_next    = '0;
            ofy_next    = '0;
            ofz_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg   <= 1'b0;
            pc_reg     <= '0;
            ovalid_reg <= 1'b0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            dz_reg     <= '0;
            accx_reg   <= '0;
            accy_reg   <= '0;
            accz_reg   <= '0;
        end else begin
            busy_reg   <= busy_next;
            pc_reg     <= pc_next;
            ovalid_reg <= ovalid_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            dz_reg     <= dz_next;
            accx_reg   <= accx_next;
            accy_reg   <= accy_next;
            accz_reg   <= accz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        last_reg  <= last_next;
        av_reg    <= av_next;
        bv_reg    <= bv_next;
        cv_reg    <= cv_next;
        sv_reg    <= sv_next;
        pv_reg    <= pv_next;
        kx_reg    <= kx_next;
        ky_reg    <= ky_next;
        kz_reg    <= kz_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        w_reg     <= w_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        okind_reg <= okind_next;
        oa_reg    <= oa_next;
        ob_reg    <= ob_next;
        ofx_reg   <= ofx_next;
        ofy_reg   <= ofy_next;
        ofz_reg   <= ofz_next;
    end

    a_start_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> busy_reg && op_reg == $past(operation) &&
        pc_reg == ($past(operation) ? ekf_pkg::PAIR_START : ekf_pkg::FIELD_START))
        else $error("Program did not start at the entry for the accepted operation.");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit_field |=> accx_reg == '0 && accy_reg == '0 && accz_reg == '0)
        else $error("Accumulators not cleared after a field result.");

    a_emit_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_field || emit_pair) |-> busy_reg &&
        (ctrl.seq == ekf_pkg::SQ_END_FIELD || ctrl.seq == ekf_pkg::SQ_END_PAIR))
        else $error("Result emitted outside a final program step.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_field || emit_pair) |-> !ovalid_reg || !out_stall)
        else $error("Result register overwritten while its beat is stalled.");

    a_pair_zero_field: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !okind_reg) |-> ofx_reg == '0 && ofy_reg == '0 && ofz_reg == '0)
        else $error("Update result carries a nonzero field vector.");

endmodule

`default_nettype wire
